>>> hdl/template_delimiter_splitter_core_defines.svh
// Assertion macros shared by the splitter RTL.
`ifndef TEMPLATE_DELIMITER_SPLITTER_CORE_DEFINES_SVH
`define TEMPLATE_DELIMITER_SPLITTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDS_ASSERT(lbl, prop, msg)
`define TDS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> hdl/tdsplit_pkg.sv
`timescale 1ns / 1ps
package tdsplit_pkg;

  localparam int MAX_DELIM_LEN = 4;
  // Usable delimiter length is capped at four bytes by the 32-bit registers.
  localparam logic [2:0] LEN_CAP =
      (MAX_DELIM_LEN > 4) ? 3'd4 : ((MAX_DELIM_LEN < 1) ? 3'd1 : 3'(MAX_DELIM_LEN));

  localparam int CFG_ADDR_W = 4;

  localparam logic [31:0] OPEN_BYTES_RST  = 32'h0000_7B7B;
  localparam logic [2:0]  OPEN_LEN_RST    = 3'd2;
  localparam logic [31:0] CLOSE_BYTES_RST = 32'h0000_7D7D;
  localparam logic [2:0]  CLOSE_LEN_RST   = 3'd2;

  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_UNIT_END   = 2'd1;
  localparam logic [1:0] KIND_STREAM_END = 2'd2;
  localparam logic [1:0] KIND_UNUSED     = 2'd3;

  typedef enum logic [1:0] {
    REG_OPEN_BYTES  = 2'd0,
    REG_OPEN_LEN    = 2'd1,
    REG_CLOSE_BYTES = 2'd2,
    REG_CLOSE_LEN   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_EOI   = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_channel;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] open_bytes;
    logic [2:0]  open_len;
    logic [31:0] close_bytes;
    logic [2:0]  close_len;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       has_results;
    logic [1:0] last_idx;
    logic       out_free;
  } dp_status_t;

  function automatic logic [7:0] delim_byte(input logic [31:0] bytes, input logic [1:0] idx);
    delim_byte = bytes[{idx, 3'b000} +: 8];
  endfunction

endpackage

>>> hdl/tdsplit_regs.sv
`timescale 1ns / 1ps
module tdsplit_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tdsplit_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output tdsplit_pkg::cfg_t                  cfg
);
  import tdsplit_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_OPEN_BYTES:  cfg_nxt.open_bytes  = pwdata;
        REG_OPEN_LEN:    cfg_nxt.open_len    = pwdata[2:0];
        REG_CLOSE_BYTES: cfg_nxt.close_bytes = pwdata;
        REG_CLOSE_LEN:   cfg_nxt.close_len   = pwdata[2:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OPEN_BYTES:  prdata = cfg_r.open_bytes;
      REG_OPEN_LEN:    prdata = {29'd0, cfg_r.open_len};
      REG_CLOSE_BYTES: prdata = cfg_r.close_bytes;
      REG_CLOSE_LEN:   prdata = {29'd0, cfg_r.close_len};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_bytes  <= OPEN_BYTES_RST;
      cfg_r.open_len    <= OPEN_LEN_RST;
      cfg_r.close_bytes <= CLOSE_BYTES_RST;
      cfg_r.close_len   <= CLOSE_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hdl/tdsplit_dp.sv
`timescale 1ns / 1ps
module tdsplit_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tdsplit_pkg::cfg_t       cfg,
  input  tdsplit_pkg::in_item_t   in_data,
  input  tdsplit_pkg::dp_cmd_t    cmd,
  output tdsplit_pkg::dp_status_t status,
  output logic                    out_valid,
  output tdsplit_pkg::out_item_t  out_data,
  input  logic                    out_stall
);
  import tdsplit_pkg::*;

  function automatic logic [2:0] eff_len(input logic [2:0] len);
    logic [2:0] l;
    l = len;
    if (l < 3'd1) l = 3'd1;
    if (l > LEN_CAP) l = LEN_CAP;
    eff_len = l;
  endfunction

  logic       mode_r, mode_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  action_t    act_r, act_nxt;
  logic [7:0] byte_r;
  logic       chan_r;
  logic [1:0] last_idx_r, last_idx_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r, result;

  logic [31:0] cur_bytes, emit_bytes;
  logic [2:0]  cur_len, cnt_inc;
  logic        match;

  assign cur_bytes  = mode_r ? cfg.close_bytes : cfg.open_bytes;
  assign cur_len    = eff_len(mode_r ? cfg.close_len : cfg.open_len);
  assign cnt_inc    = {1'b0, cnt_r} + 3'd1;
  assign match      = ({1'b0, cnt_r} < cur_len) &&
                      (in_data.in_byte == delim_byte(cur_bytes, cnt_r));

  // Decide what the accepted item does to the mode and how many results it makes.
  always_comb begin
    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    act_nxt      = ACT_NONE;
    last_idx_nxt = 2'd0;
    if (in_data.end_of_input) begin
      act_nxt      = ACT_EOI;
      last_idx_nxt = 2'd1;
      mode_nxt     = 1'b0;
      cnt_nxt      = 2'd0;
    end else if (match) begin
      if (cnt_inc >= cur_len) begin
        act_nxt  = ACT_MARK;
        mode_nxt = !mode_r;
        cnt_nxt  = 2'd0;
      end else begin
        cnt_nxt = cnt_inc[1:0];
      end
    end else if ({1'b0, cnt_r} >= cur_len) begin
      // A shortened length left the count complete: close the delimiter.
      act_nxt  = ACT_MARK;
      mode_nxt = !mode_r;
      cnt_nxt  = 2'd0;
    end else begin
      act_nxt      = ACT_FLUSH;
      last_idx_nxt = cnt_r;
      cnt_nxt      = 2'd0;
    end
  end

  // Users keep config stable as results drain (unchecked); flush reads it live.
  assign emit_bytes = chan_r ? cfg.close_bytes : cfg.open_bytes;

  always_comb begin
    result      = '0;
    result.last = (cmd.idx == last_idx_r);
    case (act_r)
      ACT_EOI: begin
        result.kind        = KIND_STREAM_END;
        result.out_channel = cmd.idx[0];
      end
      ACT_MARK: begin
        result.kind        = KIND_UNIT_END;
        result.out_channel = chan_r;
      end
      ACT_FLUSH: begin
        result.kind        = KIND_DATA;
        result.out_channel = chan_r;
        result.out_byte    = (cmd.idx < last_idx_r) ? delim_byte(emit_bytes, cmd.idx) : byte_r;
      end
      default: result = '0;
    endcase
  end

  assign status.has_results = (act_nxt != ACT_NONE);
  assign status.last_idx    = last_idx_r;
  assign status.out_free    = !out_valid_r || !out_stall;
  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      cnt_r       <= 2'd0;
      act_r       <= ACT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
        act_r  <= act_nxt;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r     <= in_data.in_byte;
      chan_r     <= mode_r;
      last_idx_r <= last_idx_nxt;
    end
    if (cmd.load) begin
      out_data_r <= result;
    end
  end

endmodule

>>> hdl/tdsplit_ctrl.sv
`timescale 1ns / 1ps
module tdsplit_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  tdsplit_pkg::dp_status_t status,
  output tdsplit_pkg::dp_cmd_t    cmd
);
  import tdsplit_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    cmd.idx    = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && status.has_results) begin
          state_nxt = ST_EMIT;
          idx_nxt   = 2'd0;
        end
      end
      ST_EMIT: begin
        // One result goes into the output register per free cycle.
        if (status.out_free) begin
          cmd.load = 1'b1;
          if (idx_r == status.last_idx) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/template_delimiter_splitter_core.sv
`timescale 1ns / 1ps
// Splits a byte stream into plain text and variable text using open and close
// delimiters set through the register port. A byte that only advances a match
// produces no result, a completed delimiter one, a broken match up to four (the
// matched bytes, then the breaking byte), and an end of input two, one per
// channel. The controller loads results one at a
// time into a single output register and holds in_stall high until the last one
// is loaded; a stalled output delays the loads further. The next byte may enter
// while the last result still waits in the output register.
`include "template_delimiter_splitter_core_defines.svh"
module template_delimiter_splitter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tdsplit_pkg::in_item_t              in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tdsplit_pkg::out_item_t             out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tdsplit_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tdsplit_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  tdsplit_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdsplit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tdsplit_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  `TDS_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `TDS_ASSERT(a_eoi_holds_input, (in_valid && !in_stall && in_data.end_of_input) |=> in_stall, "end of input did not start result drain")
  `TDS_ASSERT(a_load_when_free, cmd.load |-> status.out_free, "result loaded over a waiting transfer")
  `TDS_ASSERT(a_kind_legal, out_valid |-> (out_data.kind != KIND_UNUSED), "illegal result kind")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tdsplit_pkg::*;

  localparam real CLK_PERIOD = 4.0;
  localparam int  QUIET_LIMIT = 2000;
  localparam int  SETTLE_CYCLES = 10;
  localparam int  LEN_MAX = (MAX_DELIM_LEN > 4) ? 4 : ((MAX_DELIM_LEN < 1) ? 1 : MAX_DELIM_LEN);
  localparam int  RANDOM_PHASES = 6;
  localparam int  ITEMS_PER_PHASE = 25;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Our own copy of the delimiter registers and the splitter state.
  logic [31:0] open_bytes = OPEN_BYTES_RST;
  logic [2:0]  open_len = OPEN_LEN_RST;
  logic [31:0] close_bytes = CLOSE_BYTES_RST;
  logic [2:0]  close_len = CLOSE_LEN_RST;
  logic        in_var = 1'b0;
  int unsigned match_cnt = 0;

  out_item_t   pending_pieces[$];
  int          error_count = 0;
  bit          no_idle = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned out_hold;

  template_delimiter_splitter_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  function automatic int unsigned usable_len(input logic [2:0] raw);
    int unsigned n;
    n = {29'd0, raw};
    if (n < 1) n = 1;
    if (n > LEN_MAX) n = LEN_MAX;
    return n;
  endfunction

  function automatic logic [31:0] random_delim();
    // Repeated bytes make overlapping partial matches likely.
    if ($urandom_range(0, 1) == 0) return {4{8'($urandom_range(0, 255))}};
    return $urandom;
  endfunction

  // Works out the results one accepted byte causes and updates the state.
  task automatic split_byte(input in_item_t item);
    out_item_t   piece;
    out_item_t   batch[$];
    logic [31:0] delim;
    int unsigned len;
    int unsigned i;
    delim = in_var ? close_bytes : open_bytes;
    len = usable_len(in_var ? close_len : open_len);
    piece = '0;
    if (item.end_of_input) begin
      piece.kind = KIND_STREAM_END;
      piece.out_channel = 1'b0;
      batch.push_back(piece);
      piece.out_channel = 1'b1;
      batch.push_back(piece);
      in_var = 1'b0;
      match_cnt = 0;
    end else begin
      if (match_cnt < len && item.in_byte == delim[8*match_cnt +: 8]) begin
        match_cnt++;
      end else if (match_cnt < len) begin
        piece.kind = KIND_DATA;
        piece.out_channel = in_var;
        for (i = 0; i < match_cnt && i < 3; i++) begin
          piece.out_byte = delim[8*i +: 8];
          batch.push_back(piece);
        end
        piece.out_byte = item.in_byte;
        batch.push_back(piece);
        match_cnt = 0;
      end
      // A count left at or above a shortened length also completes the delimiter.
      if (match_cnt >= len) begin
        piece = '0;
        piece.kind = KIND_UNIT_END;
        piece.out_channel = in_var;
        batch.push_back(piece);
        in_var = ~in_var;
        match_cnt = 0;
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) pending_pieces.push_back(batch[k]);
  endtask

  task automatic check_piece(input out_item_t got);
    out_item_t want;
    if (pending_pieces.size() == 0) begin
      $error("out_data: no result expected, got byte %0d channel %0d kind %0d last %0d",
             got.out_byte, got.out_channel, got.kind, got.last);
      error_count++;
    end else begin
      want = pending_pieces.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
        error_count++;
      end
      if (got.out_channel !== want.out_channel) begin
        $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
        error_count++;
      end
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_piece(out_data);
  end

  // Result side: before each transfer, raise stall for a randomly drawn hold, skipped when no_idle is set.
  always begin
    out_hold = no_idle ? 0 : $urandom_range(0, 19);
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      repeat (out_hold) @(negedge clk);
    end
    out_stall <= 1'b0;
    @(posedge clk);
    while (!(out_valid && !out_stall)) @(posedge clk);
    @(negedge clk);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, end_of_input: eoi};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    split_byte(in_data);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  // Drops valid and waits out every result plus a margin for bytes that only
  // advance a match, so that a register write finds the block idle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_OPEN_BYTES:  open_bytes = value;
      REG_OPEN_LEN:    open_len = value[2:0];
      REG_CLOSE_BYTES: close_bytes = value;
      REG_CLOSE_LEN:   close_len = value[2:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_delims(input logic [31:0] ob, input logic [2:0] ol,
                            input logic [31:0] cb, input logic [2:0] cl);
    wait_idle();
    write_reg(REG_OPEN_BYTES, ob);
    write_reg(REG_OPEN_LEN, {29'd0, ol});
    write_reg(REG_CLOSE_BYTES, cb);
    write_reg(REG_CLOSE_LEN, {29'd0, cl});
  endtask

  // Delimiters as they come out of reset: unit ends, a broken close match,
  // the byte values that once clashed with sentinels, and a partial match
  // dropped by end of input.
  task automatic test_default_delims();
    send_item(8'h00, 1'b0);
    send_text("{{");
    send_item(8'hFF, 1'b0);
    send_item(8'hFE, 1'b0);
    send_text("}x}}");
    send_text("{");
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Length zero acts as one and seven as the four-byte cap; a broken
  // three-byte match gives the largest flush.
  task automatic test_length_extremes();
    set_delims(32'hFFFF_FFFF, 3'd7, 32'h0000_0000, 3'd0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h01, 1'b0);
    repeat (4) send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
  endtask

  // Registers rewritten while a match is in progress.
  task automatic test_retune_mid_match();
    set_delims(32'h6463_6261, 3'd4, 32'h0000_7978, 3'd2);
    send_text("abc");
    wait_idle();
    write_reg(REG_OPEN_LEN, 32'd2);
    send_text("z");
    send_text("x");
    wait_idle();
    write_reg(REG_CLOSE_BYTES, 32'h0000_7170);
    send_text("r");
    send_item(8'h00, 1'b1);
  endtask

  // Whole delimiters and random text, plus broken matches and
  // stream ends, under a fresh register setting in each phase.
  task automatic test_random_streams();
    int unsigned phase;
    int unsigned sent;
    int unsigned r;
    int unsigned n;
    int unsigned len;
    logic [31:0] delim;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_delims(OPEN_BYTES_RST, OPEN_LEN_RST, CLOSE_BYTES_RST, CLOSE_LEN_RST);
        1: set_delims(32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 3'd7);
        default: set_delims(random_delim(), 3'($urandom_range(0, 7)),
                            random_delim(), 3'($urandom_range(0, 7)));
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
        delim = in_var ? close_bytes : open_bytes;
        len = usable_len(in_var ? close_len : open_len);
        r = $urandom_range(0, 99);
        if (r < 40) begin
          for (n = 0; n < len; n++) send_item(delim[8*n +: 8], 1'b0);
          sent += len;
        end else if (r < 60) begin
          n = $urandom_range(0, len - 1);
          for (int i = 0; i < n; i++) send_item(delim[8*i +: 8], 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'b0);
          sent += n + 1;
        end else if (r < 96) begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            send_item(($urandom_range(0, 3) == 0) ? delim[7:0] : 8'($urandom_range(0, 255)),
                      1'b0);
          end
          sent += n;
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'b1);
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_delims();
    test_length_extremes();
    test_retune_mid_match();
    test_random_streams();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
